@@ rtl/gpa_pkg.sv @@
// Shared types and constants for the GF(2) polynomial arithmetic unit.
// Used by gpa_ctrl, gpa_dpath and gf2_poly_alu_unit; depends on nothing else.
`default_nettype none

package gpa_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned DATA_W = 64;
  localparam int unsigned FUNC_W = 2;

  // Default internal polynomial width.
  localparam int unsigned POLY_WIDTH_DEF = 64;

  // Operation codes carried on the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_MUL = 2'd0,
    FUNC_REM = 2'd1,
    FUNC_QUO = 2'd2,
    FUNC_GCD = 2'd3
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the operands and start a new item
    logic load_mul;   // the load is for a multiply: iterate over the low half only
    logic norm_step;  // lower the divisor degree pointer by one
    logic div_step;   // one long-division step at the dividend pointer
    logic swap;       // Euclid swap: divisor becomes dividend, remainder divisor
    logic mul_step;   // one shift-and-xor step of the carry-less multiply
    logic out_wr;     // write the output register
    logic res_q;      // result comes from the quotient/product register
    logic res_dz;     // divide-by-zero flag for the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic b_bit;     // divisor bit at the degree pointer
    logic db_zero;   // divisor degree pointer is zero
    logic da_eq_db;  // dividend pointer has reached the divisor degree
    logic da_zero;   // dividend/iteration pointer is zero
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/gpa_dpath.sv @@
// Datapath of the GF(2) polynomial unit: operand, quotient and output registers.
// Depends on gpa_pkg for the command and status structs.
`default_nettype none

module gpa_dpath #(
  parameter int unsigned POLY_WIDTH = gpa_pkg::POLY_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire gpa_pkg::cmd_t              cmd,
  input  wire logic [gpa_pkg::DATA_W-1:0] in_operand_a,
  input  wire logic [gpa_pkg::DATA_W-1:0] in_operand_b,
  output gpa_pkg::sts_t                   sts,
  output logic [gpa_pkg::DATA_W-1:0]      out_poly_result,
  output logic                            out_divide_by_zero
);

  localparam int unsigned W  = POLY_WIDTH;
  localparam int unsigned H  = POLY_WIDTH / 2;
  localparam int unsigned DW = $clog2(POLY_WIDTH);
  localparam logic [W-1:0] HALF_MASK = {{(W-H){1'b0}}, {H{1'b1}}};

  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [DW-1:0] da_r, da_nxt;
  logic [DW-1:0] db_r, db_nxt;
  logic [gpa_pkg::DATA_W-1:0] res_r, res_nxt;
  logic          dz_r, dz_nxt;

  logic [DW-1:0] sh;
  logic [W-1:0]  a_div;
  logic [W-1:0]  q_div;
  logic [W-1:0]  mul_add;

  // One long-division step: cancel the dividend term at da with the
  // divisor shifted up to that degree.
  always_comb begin
    sh    = da_r - db_r;
    a_div = a_r;
    q_div = q_r;
    if (a_r[da_r]) begin
      a_div = a_r ^ (b_r << sh);
      q_div = q_r | (W'(1) << sh);
    end
  end

  assign mul_add = a_r[H-1] ? (b_r & HALF_MASK) : '0;

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    q_nxt   = q_r;
    da_nxt  = da_r;
    db_nxt  = db_r;
    res_nxt = res_r;
    dz_nxt  = dz_r;
    if (cmd.load) begin
      a_nxt  = in_operand_a[W-1:0];
      b_nxt  = in_operand_b[W-1:0];
      q_nxt  = '0;
      // A multiply walks the low half of operand a, MSB first.
      da_nxt = cmd.load_mul ? DW'(H - 1) : DW'(W - 1);
      db_nxt = DW'(W - 1);
    end
    if (cmd.norm_step) begin
      db_nxt = db_r - 1'b1;
    end
    if (cmd.div_step) begin
      a_nxt  = a_div;
      q_nxt  = q_div;
      da_nxt = da_r - 1'b1;
    end
    if (cmd.swap) begin
      a_nxt  = b_r;
      b_nxt  = a_div;
      da_nxt = db_r;
      db_nxt = db_r - 1'b1;
    end
    if (cmd.mul_step) begin
      a_nxt  = a_r << 1;
      q_nxt  = (q_r << 1) ^ mul_add;
      da_nxt = da_r - 1'b1;
    end
    if (cmd.out_wr) begin
      res_nxt = cmd.res_q ? gpa_pkg::DATA_W'(q_r) : gpa_pkg::DATA_W'(a_r);
      dz_nxt  = cmd.res_dz;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    q_r   <= q_nxt;
    da_r  <= da_nxt;
    db_r  <= db_nxt;
    res_r <= res_nxt;
    dz_r  <= dz_nxt;
  end

  assign sts.b_bit    = b_r[db_r];
  assign sts.db_zero  = (db_r == '0);
  assign sts.da_eq_db = (da_r == db_r);
  assign sts.da_zero  = (da_r == '0);

  assign out_poly_result    = res_r;
  assign out_divide_by_zero = dz_r;

endmodule

`default_nettype wire

@@ rtl/gpa_ctrl.sv @@
// Controller state machine of the GF(2) polynomial unit and its handshakes.
// Depends on gpa_pkg for the operation codes and the command/status structs.
`default_nettype none

module gpa_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [gpa_pkg::FUNC_W-1:0] in_func,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  input  wire gpa_pkg::sts_t              sts,
  output gpa_pkg::cmd_t                   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_NORM = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  gpa_pkg::func_t func_r, func_nxt;
  logic           dz_r, dz_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    dz_nxt    = dz_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.load_mul = (gpa_pkg::func_t'(in_func) == gpa_pkg::FUNC_MUL);
          func_nxt = gpa_pkg::func_t'(in_func);
          dz_nxt   = 1'b0;
          state_nxt = (gpa_pkg::func_t'(in_func) == gpa_pkg::FUNC_MUL) ? ST_MUL : ST_NORM;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.da_zero) begin
          state_nxt = ST_FIN;
        end
      end
      ST_NORM: begin
        if (sts.b_bit) begin
          state_nxt = ST_DIV;
        end else if (sts.db_zero) begin
          // Divisor is zero: flag it for remainder and quotient.
          dz_nxt    = (func_r != gpa_pkg::FUNC_GCD);
          state_nxt = ST_FIN;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.da_eq_db) begin
          if (func_r == gpa_pkg::FUNC_GCD) begin
            cmd.swap  = 1'b1;
            // A constant divisor leaves a zero remainder, so Euclid ends here.
            state_nxt = sts.db_zero ? ST_FIN : ST_NORM;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.out_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    cmd.res_q  = (func_r == gpa_pkg::FUNC_MUL) || (func_r == gpa_pkg::FUNC_QUO);
    cmd.res_dz = dz_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_wr) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    dz_r   <= dz_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/gf2_poly_alu_unit.sv @@
// Top level of the GF(2) polynomial arithmetic unit (multiply, remainder,
// quotient, gcd). Depends on gpa_pkg, gpa_ctrl and gpa_dpath.
//
// Usage: an item is transferred on the input channel when in_valid is high
// and in_stall is low. It carries in_func (0 multiply, 1 remainder,
// 2 quotient, 3 gcd) and two packed polynomials, bit i being the coefficient
// of x^i. Each item gives exactly one result transfer on the output channel
// (out_valid high, out_stall low): out_poly_result and out_divide_by_zero.
// One item is worked on at a time; in_stall is high from the transfer until
// the result has been written to the output register, so the next transfer
// can follow in the cycle after that write. Multiply is a one-bit-per-cycle
// shift-and-xor loop; remainder and quotient run a divisor degree search,
// then one dividend degree per cycle; gcd repeats the divide and the degree
// search. A zero divisor flags divide_by_zero and returns the dividend
// (remainder) or zero (quotient). A new item is taken while a finished
// result waits in the output register; a stalled receiver only holds the
// next result back until the register frees. Reset (rst_n low, synchronous)
// returns the controller to idle and drops out_valid.
`default_nettype none

module gf2_poly_alu_unit #(
  parameter int unsigned POLY_WIDTH = gpa_pkg::POLY_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [gpa_pkg::FUNC_W-1:0] in_func,
  input  wire logic [gpa_pkg::DATA_W-1:0] in_operand_a,
  input  wire logic [gpa_pkg::DATA_W-1:0] in_operand_b,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [gpa_pkg::DATA_W-1:0]      out_poly_result,
  output logic                            out_divide_by_zero
);

  gpa_pkg::cmd_t cmd;
  gpa_pkg::sts_t sts;

  // The controller sequences the multiply, degree search, division and
  // Euclid swaps; the datapath holds every polynomial register.
  gpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gpa_dpath #(
    .POLY_WIDTH (POLY_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .cmd                (cmd),
    .in_operand_a       (in_operand_a),
    .in_operand_b       (in_operand_b),
    .sts                (sts),
    .out_poly_result    (out_poly_result),
    .out_divide_by_zero (out_divide_by_zero)
  );

  // Operands are captured only on an input transfer.
  a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && !in_stall))
    else $error("operand load without an input transfer");

  // A result that has not been taken is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_wr |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  // Division steps run only with the divisor's leading term located.
  a_div_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> sts.b_bit)
    else $error("division step with unnormalized divisor");

  // While an item is in flight no new item is accepted.
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.mul_step || cmd.norm_step) |-> in_stall)
    else $error("input accepted while busy");

endmodule

`default_nettype wire

@@ dv/gf2_poly_alu_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gf2_poly_alu_unit: a table of directed items, then random
// polynomials, each result transfer checked against its row or a behavioral GF(2) model.
// Depends on gpa_pkg and the RTL of gf2_poly_alu_unit.

module gf2_poly_alu_unit_tb;
  import gpa_pkg::*;

  localparam int unsigned PW           = POLY_WIDTH_DEF;
  localparam int          RANDOM_ITEMS = 1550;
  // Longest quiet stretch of a correct run: a slow gcd, a receiver stall run or a
  // sender gap. The limit takes that several times over.
  localparam int          IDLE_LIMIT   = 4000;
  // Cycles to watch for stray results once every expected one has arrived.
  localparam int          DRAIN_CYCLES = 400;
  localparam int          PRINT_CAP    = 100;

  typedef logic [DATA_W-1:0] poly_t;

  typedef struct {
    poly_t poly;
    logic  dz;
  } alu_result_t;

  // One row of the directed table. Where typed is set, the expected result is
  // written in the row; otherwise the arithmetic model supplies it.
  typedef struct {
    func_t op;
    poly_t a;
    poly_t b;
    bit    typed;
    poly_t want_poly;
    logic  want_dz;
  } stim_row_t;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_RUNS
  } stall_mode_t;

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func            = '0;
  poly_t             in_operand_a       = '0;
  poly_t             in_operand_b       = '0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  poly_t             out_poly_result;
  logic              out_divide_by_zero;

  // Results still owed by the block, oldest first.
  alu_result_t pending_results[$];
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  int          burst_left     = 0;

  gf2_poly_alu_unit #(
    .POLY_WIDTH(PW)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_poly_result   (out_poly_result),
    .out_divide_by_zero(out_divide_by_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // GF(2) arithmetic model
  // ---------------------------------------------------------------------------

  function automatic poly_t width_mask();
    return (PW >= DATA_W) ? {DATA_W{1'b1}} : ((poly_t'(1) << PW) - 1);
  endfunction

  // The multiply only looks at the low half of each operand.
  function automatic poly_t half_mask();
    return (poly_t'(1) << (PW / 2)) - 1;
  endfunction

  // Degree of a polynomial, -1 for the zero polynomial.
  function automatic int poly_degree(poly_t v);
    int d;
    int i;
    d = -1;
    for (i = 0; i < DATA_W; i++) begin
      if (v[i]) d = i;
    end
    return d;
  endfunction

  function automatic poly_t clmul(poly_t a, poly_t b);
    poly_t acc;
    int    i;
    acc = '0;
    for (i = 0; i < DATA_W; i++) begin
      if (a[i]) acc ^= b << i;
    end
    return acc;
  endfunction

  // Schoolbook long division; the divisor must be nonzero.
  function automatic void poly_divide(input poly_t num, input poly_t den,
                                      output poly_t quo, output poly_t rem);
    int dd;
    int dn;
    dd  = poly_degree(den);
    quo = '0;
    dn  = poly_degree(num);
    while (num != '0 && dn >= dd) begin
      num ^= den << (dn - dd);
      quo ^= poly_t'(1) << (dn - dd);
      dn  = poly_degree(num);
    end
    rem = num;
  endfunction

  function automatic poly_t euclid_gcd(poly_t a, poly_t b);
    poly_t q;
    poly_t r;
    while (b != '0) begin
      poly_divide(a, b, q, r);
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic alu_result_t gf2_compute(func_t op, poly_t a, poly_t b);
    alu_result_t res;
    poly_t       q;
    poly_t       r;
    a      &= width_mask();
    b      &= width_mask();
    res.dz = 1'b0;
    case (op)
      FUNC_MUL: begin
        res.poly = clmul(a & half_mask(), b & half_mask());
      end
      FUNC_REM: begin
        if (b == '0) begin
          res.poly = a;
          res.dz   = 1'b1;
        end else begin
          poly_divide(a, b, q, r);
          res.poly = r;
        end
      end
      FUNC_QUO: begin
        if (b == '0) begin
          res.poly = '0;
          res.dz   = 1'b1;
        end else begin
          poly_divide(a, b, q, r);
          res.poly = q;
        end
      end
      default: begin
        res.poly = euclid_gcd(a, b);
      end
    endcase
    res.poly &= width_mask();
    return res;
  endfunction

  // Random operand with a spread of shapes: zero, single terms, low degree,
  // runs of ones and dense full-width words.
  function automatic poly_t rand_poly();
    poly_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0:       v = '0;
      1, 2:    v = poly_t'(1) << $urandom_range(0, DATA_W - 1);
      3, 4, 5: v = v >> $urandom_range(1, DATA_W - 1);
      6:       v = v >> $urandom_range(DATA_W - 8, DATA_W - 1);
      7:       v = {DATA_W{1'b1}} >> $urandom_range(0, DATA_W - 1);
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input poly_t got, input poly_t want);
    if (mismatch_count < PRINT_CAP) begin
      $display("tb: mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Every result transfer is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_poly_result, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_poly_result !== want.poly) begin
          report_mismatch("poly_result", out_poly_result, want.poly);
        end
        if (out_divide_by_zero !== want.dz) begin
          report_mismatch("divide_by_zero", poly_t'(out_divide_by_zero), poly_t'(want.dz));
        end
      end
    end
  end

  // Receiver back-pressure. The mode is redrawn at random times: no stall
  // at all, a coin flip each cycle, or alternating runs of stall and free.
  stall_mode_t stall_mode  = STALL_NONE;
  int          mode_left   = 0;
  int          run_left    = 0;
  logic        stall_level = 1'b0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(64, 512);
      run_left   = 0;
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_COIN: begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        if (run_left == 0) begin
          stall_level = ~stall_level;
          run_left    = $urandom_range(1, 40);
        end
        run_left--;
        out_stall <= stall_level;
      end
    endcase
  end

  // A run with no transfer on either channel for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Presents one item, holds it until the transfer, records what it must give,
  // and then either keeps valid up for the next item of the burst or idles.
  task automatic transfer_item(input func_t op, input poly_t a, input poly_t b,
                               input alu_result_t want);
    int gap;
    in_valid     <= 1'b1;
    in_func      <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(want);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Gaps are spread so that valid rises at every point of the block's work.
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = $urandom_range(1, 5);
        5, 6, 7, 8:    gap = $urandom_range(6, 60);
        default:       gap = $urandom_range(61, 250);
      endcase
      burst_left = $urandom_range(0, 20);
      in_valid   <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    stim_row_t   rows[$];
    stim_row_t   row;
    alu_result_t want;
    func_t       op;
    poly_t       a;
    poly_t       b;
    poly_t       g;
    int          n;

    // Multiply: zero operand, full low halves, upper halves ignored.
    rows.push_back('{FUNC_MUL, 64'h0, {64{1'b1}}, 1'b1, 64'h0, 1'b0});
    rows.push_back('{FUNC_MUL, {64{1'b1}}, {64{1'b1}}, 1'b0, 64'h0, 1'b0});
    rows.push_back('{FUNC_MUL, 64'h1, 64'hDEAD_BEEF_CAFE_F00D, 1'b1,
                     64'h0000_0000_CAFE_F00D, 1'b0});
    rows.push_back('{FUNC_MUL, 64'h8000_0000, 64'h8000_0000, 1'b1,
                     64'h4000_0000_0000_0000, 1'b0});
    rows.push_back('{FUNC_MUL, 64'hFFFF_FFFF_0000_0000, {64{1'b1}}, 1'b1, 64'h0, 1'b0});
    // Zero divisor: remainder returns the dividend, quotient returns zero.
    rows.push_back('{FUNC_REM, {64{1'b1}}, 64'h0, 1'b1, {64{1'b1}}, 1'b1});
    rows.push_back('{FUNC_QUO, {64{1'b1}}, 64'h0, 1'b1, 64'h0, 1'b1});
    rows.push_back('{FUNC_REM, 64'h0, 64'h0, 1'b1, 64'h0, 1'b1});
    rows.push_back('{FUNC_QUO, 64'h0, 64'h0, 1'b1, 64'h0, 1'b1});
    // Divisor of degree zero, a dividend below or at the divisor degree, and divisor x + 1.
    rows.push_back('{FUNC_REM, {64{1'b1}}, 64'h1, 1'b1, 64'h0, 1'b0});
    rows.push_back('{FUNC_QUO, {64{1'b1}}, 64'h1, 1'b1, {64{1'b1}}, 1'b0});
    rows.push_back('{FUNC_REM, 64'h5, 64'h8000_0000_0000_0000, 1'b1, 64'h5, 1'b0});
    rows.push_back('{FUNC_QUO, 64'h5, 64'h8000_0000_0000_0000, 1'b1, 64'h0, 1'b0});
    rows.push_back('{FUNC_REM, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1,
                     64'h0, 1'b0});
    rows.push_back('{FUNC_QUO, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1,
                     64'h1, 1'b0});
    rows.push_back('{FUNC_REM, {64{1'b1}}, 64'h3, 1'b0, 64'h0, 1'b0});
    rows.push_back('{FUNC_QUO, {64{1'b1}}, 64'h3, 1'b0, 64'h0, 1'b0});
    rows.push_back('{FUNC_QUO, 64'h8000_0000_0000_0000, 64'h3, 1'b0, 64'h0, 1'b0});
    // Gcd with zero operands, equal operands, single-term operands and small divisors.
    rows.push_back('{FUNC_GCD, {64{1'b1}}, 64'h0, 1'b1, {64{1'b1}}, 1'b0});
    rows.push_back('{FUNC_GCD, 64'h0, 64'h0123_4567_89AB_CDEF, 1'b1,
                     64'h0123_4567_89AB_CDEF, 1'b0});
    rows.push_back('{FUNC_GCD, 64'h0, 64'h0, 1'b1, 64'h0, 1'b0});
    rows.push_back('{FUNC_GCD, {64{1'b1}}, {64{1'b1}}, 1'b1, {64{1'b1}}, 1'b0});
    rows.push_back('{FUNC_GCD, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b1,
                     64'h4000_0000_0000_0000, 1'b0});
    rows.push_back('{FUNC_GCD, 64'hA5A5_A5A5_A5A5_A5A5, 64'h1, 1'b1, 64'h1, 1'b0});
    rows.push_back('{FUNC_GCD, {64{1'b1}}, 64'h3, 1'b0, 64'h0, 1'b0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      row = rows[i];
      if (row.typed) begin
        want.poly = row.want_poly;
        want.dz   = row.want_dz;
      end else begin
        want = gf2_compute(row.op, row.a, row.b);
      end
      transfer_item(row.op, row.a, row.b, want);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      op = func_t'($urandom_range(0, 3));
      a  = rand_poly();
      b  = rand_poly();
      if (op == FUNC_GCD && $urandom_range(0, 2) == 0) begin
        // Give both operands a shared factor so the gcd is not trivially one.
        g = rand_poly() & half_mask();
        if (g == '0) g = poly_t'(3);
        a = clmul(a & half_mask(), g);
        b = clmul(b & half_mask(), g);
      end else if ($urandom_range(0, 19) == 0) begin
        b = a;
      end
      transfer_item(op, a, b, gf2_compute(op, a, b));
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/gpa_pkg.sv
rtl/gpa_dpath.sv
rtl/gpa_ctrl.sv
rtl/gf2_poly_alu_unit.sv
dv/gf2_poly_alu_unit_tb.sv
